@@ hw/rtl/bpdc_pkg.sv @@
// Shared constants, codes and types of the button press duration classifier.
`default_nettype none
package bpdc_pkg;

  localparam int unsigned TsW     = 32;
  localparam int unsigned DurW    = 16;
  localparam int unsigned InhW    = 22;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned ApbDw   = 32;
  localparam int unsigned ApbAw   = 5;

  // Reset values of the configuration registers
  localparam logic            EnabledRst   = 1'b0;
  localparam logic [DurW-1:0] ShortMinRst  = 16'd50;
  localparam logic [DurW-1:0] LongRst      = 16'd3000;
  localparam logic [DurW-1:0] VeryLongRst  = 16'd10000;
  localparam logic [DurW-1:0] UltraLongRst = 16'd20000;
  localparam logic [InhW-1:0] InhibitRst   = 22'd300000;
  localparam logic [DurW-1:0] LeakTestRst  = 16'd2000;

  typedef enum logic [2:0] {
    REG_ENABLED    = 3'd0,
    REG_SHORT_MIN  = 3'd1,
    REG_LONG       = 3'd2,
    REG_VERY_LONG  = 3'd3,
    REG_ULTRA_LONG = 3'd4,
    REG_INHIBIT    = 3'd5,
    REG_LEAK_TEST  = 3'd6
  } reg_idx_t;

  typedef enum logic [CodeW-1:0] {
    REQ_NONE   = 2'd0,
    REQ_CONFIG = 2'd1,
    REQ_FULL   = 2'd2
  } req_code_t;

  typedef enum logic [CodeW-1:0] {
    BEEP_NONE   = 2'd0,
    BEEP_SHORT  = 2'd1,
    BEEP_HOLD   = 2'd2,
    BEEP_DOUBLE = 2'd3
  } beep_code_t;

endpackage
`default_nettype wire

@@ hw/rtl/button_press_duration_classifier_unit.sv @@
// Top level of the button press duration classifier: input stage, update logic, result stage.
`default_nettype none
// An accepted request passes the input register, then the result register, to its result.
// Throughput: one request per cycle unless a stalled result holds the pipeline; the update is
//   one pass of compare/add logic between the input register and the result/state registers.
// Reset (rst_n low, synchronous): both stages empty, all tracking state cleared,
//   configuration registers back to their defaults (block disabled).
module button_press_duration_classifier_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  // request channel
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [bpdc_pkg::TsW-1:0]        in_now_ms,
  input  wire                             in_pressed,
  input  wire                             in_ext_reset_request,
  input  wire                             in_ext_reset_full,
  // result channel
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_test_leak,
  output logic                            out_inhibit_sleep,
  output logic                            out_hold_active,
  output logic [bpdc_pkg::CodeW-1:0]      out_reset_request,
  output logic [bpdc_pkg::CodeW-1:0]      out_beep,
  // configuration port
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [bpdc_pkg::ApbAw-1:0]      paddr,
  input  wire  [bpdc_pkg::ApbDw-1:0]      pwdata,
  output logic [bpdc_pkg::ApbDw-1:0]      prdata,
  output logic                            pready
);
  import bpdc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic            enabled_r;
  logic [DurW-1:0] short_min_r;
  logic [DurW-1:0] long_r;
  logic [DurW-1:0] very_long_r;
  logic [DurW-1:0] ultra_long_r;
  logic [InhW-1:0] inhibit_len_r;
  logic [DurW-1:0] leak_len_r;

  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ApbAw-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= EnabledRst;
      short_min_r   <= ShortMinRst;
      long_r        <= LongRst;
      very_long_r   <= VeryLongRst;
      ultra_long_r  <= UltraLongRst;
      inhibit_len_r <= InhibitRst;
      leak_len_r    <= LeakTestRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ENABLED:    enabled_r     <= pwdata[0];
        REG_SHORT_MIN:  short_min_r   <= pwdata[DurW-1:0];
        REG_LONG:       long_r        <= pwdata[DurW-1:0];
        REG_VERY_LONG:  very_long_r   <= pwdata[DurW-1:0];
        REG_ULTRA_LONG: ultra_long_r  <= pwdata[DurW-1:0];
        REG_INHIBIT:    inhibit_len_r <= pwdata[InhW-1:0];
        REG_LEAK_TEST:  leak_len_r    <= pwdata[DurW-1:0];
        default: ;  // unmapped address: write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLED:    prdata = {{(ApbDw-1){1'b0}}, enabled_r};
      REG_SHORT_MIN:  prdata = {{(ApbDw-DurW){1'b0}}, short_min_r};
      REG_LONG:       prdata = {{(ApbDw-DurW){1'b0}}, long_r};
      REG_VERY_LONG:  prdata = {{(ApbDw-DurW){1'b0}}, very_long_r};
      REG_ULTRA_LONG: prdata = {{(ApbDw-DurW){1'b0}}, ultra_long_r};
      REG_INHIBIT:    prdata = {{(ApbDw-InhW){1'b0}}, inhibit_len_r};
      REG_LEAK_TEST:  prdata = {{(ApbDw-DurW){1'b0}}, leak_len_r};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: input stage feeds result stage; both move when the result
  // register is empty or being taken.
  // ---------------------------------------------------------------------------
  logic           s1_valid_r;
  logic [TsW-1:0] s1_now_r;
  logic           s1_pressed_r;
  logic           s1_ext_req_r;
  logic           s1_ext_full_r;
  logic           out_valid_r;
  logic           advance;
  logic           in_take;
  logic           step;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign step     = s1_valid_r && advance;   // request leaves input stage this edge

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance || !s1_valid_r) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r      <= in_now_ms;
      s1_pressed_r  <= in_pressed;
      s1_ext_req_r  <= in_ext_reset_request;
      s1_ext_full_r <= in_ext_reset_full;
    end
  end

  // ---------------------------------------------------------------------------
  // Tracking state
  // ---------------------------------------------------------------------------
  logic           prev_pressed_r;
  logic [TsW-1:0] press_start_r;
  logic [TsW-1:0] inhibit_until_r;
  logic [TsW-1:0] leak_until_r;
  logic           test_leak_r;
  logic           inhibit_r;
  logic           hold_r;

  logic           prev_pressed_nxt;
  logic [TsW-1:0] press_start_nxt;
  logic [TsW-1:0] inhibit_until_nxt;
  logic [TsW-1:0] leak_until_nxt;
  logic           test_leak_nxt;
  logic           inhibit_nxt;
  logic           hold_nxt;
  req_code_t      req_nxt;
  beep_code_t     beep_nxt;

  logic [TsW-1:0] dur;
  logic           press_edge;
  logic           held;
  logic           release_edge;
  logic           ge_long;
  logic           ge_very_long;
  logic           ge_ultra_long;
  logic           ge_short;
  logic           rst_req;
  logic           rst_full;

  // One subtract gives the press duration; thresholds compare in parallel.
  assign dur           = s1_now_r - press_start_r;
  assign press_edge    = s1_pressed_r && !prev_pressed_r;
  assign held          = s1_pressed_r && prev_pressed_r;
  assign release_edge  = !s1_pressed_r && prev_pressed_r;
  assign ge_long       = dur >= {{(TsW-DurW){1'b0}}, long_r};
  assign ge_very_long  = dur >= {{(TsW-DurW){1'b0}}, very_long_r};
  assign ge_ultra_long = dur >= {{(TsW-DurW){1'b0}}, ultra_long_r};
  assign ge_short      = dur >= {{(TsW-DurW){1'b0}}, short_min_r};

  always_comb begin
    prev_pressed_nxt  = prev_pressed_r;
    press_start_nxt   = press_start_r;
    inhibit_until_nxt = inhibit_until_r;
    leak_until_nxt    = leak_until_r;
    test_leak_nxt     = test_leak_r;
    inhibit_nxt       = inhibit_r;
    hold_nxt          = hold_r;
    req_nxt           = REQ_NONE;
    beep_nxt          = BEEP_NONE;
    rst_req           = s1_ext_req_r;
    rst_full          = s1_ext_full_r;

    if (enabled_r) begin
      if (press_edge) begin
        press_start_nxt = s1_now_r;
        hold_nxt        = 1'b1;
      end
      // long hold opens the sleep-inhibit window once
      if (held && ge_long && !inhibit_r) begin
        inhibit_until_nxt = s1_now_r + {{(TsW-InhW){1'b0}}, inhibit_len_r};
        inhibit_nxt       = 1'b1;
        beep_nxt          = BEEP_HOLD;
      end
      // release: ultra-long wins, then very-long, long, short
      if (release_edge) begin
        hold_nxt = 1'b0;
        if (ge_ultra_long) begin
          rst_req  = 1'b1;
          rst_full = 1'b1;
          beep_nxt = BEEP_DOUBLE;
        end else if (ge_very_long) begin
          rst_req  = 1'b1;
          rst_full = 1'b0;
        end else if (ge_long) begin
          // window already opened while held
        end else if (ge_short) begin
          leak_until_nxt = s1_now_r + {{(TsW-DurW){1'b0}}, leak_len_r};
          test_leak_nxt  = 1'b1;
          beep_nxt       = BEEP_SHORT;
        end
      end
      prev_pressed_nxt = s1_pressed_r;

      // window expiry: plain unsigned compare against the updated end times
      if (s1_now_r > leak_until_nxt)    test_leak_nxt = 1'b0;
      if (s1_now_r > inhibit_until_nxt) inhibit_nxt   = 1'b0;

      if (rst_req) req_nxt = rst_full ? REQ_FULL : REQ_CONFIG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pressed_r  <= 1'b0;
      press_start_r   <= '0;
      inhibit_until_r <= '0;
      leak_until_r    <= '0;
      test_leak_r     <= 1'b0;
      inhibit_r       <= 1'b0;
      hold_r          <= 1'b0;
    end else if (step) begin
      prev_pressed_r  <= prev_pressed_nxt;
      press_start_r   <= press_start_nxt;
      inhibit_until_r <= inhibit_until_nxt;
      leak_until_r    <= leak_until_nxt;
      test_leak_r     <= test_leak_nxt;
      inhibit_r       <= inhibit_nxt;
      hold_r          <= hold_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic             out_test_leak_r;
  logic             out_inhibit_r;
  logic             out_hold_r;
  logic [CodeW-1:0] out_req_r;
  logic [CodeW-1:0] out_beep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_test_leak_r <= test_leak_nxt;
      out_inhibit_r   <= inhibit_nxt;
      out_hold_r      <= hold_nxt;
      out_req_r       <= req_nxt;
      out_beep_r      <= beep_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_test_leak     = out_test_leak_r;
  assign out_inhibit_sleep = out_inhibit_r;
  assign out_hold_active   = out_hold_r;
  assign out_reset_request = out_req_r;
  assign out_beep          = out_beep_r;

endmodule
`default_nettype wire

@@ dv/button_press_duration_classifier_unit_test.sv @@
// Self-checking testbench for the button press duration classifier unit.
`default_nettype none
module button_press_duration_classifier_unit_test;
  import bpdc_pkg::*;

  // Expected flags and codes of one result
  typedef struct packed {
    logic       test_leak;
    logic       inhibit_sleep;
    logic       hold_active;
    req_code_t  req;
    beep_code_t beep;
  } tick_flags_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  wire              in_stall;
  logic [TsW-1:0]   in_now_ms = '0;
  logic             in_pressed = 1'b0;
  logic             in_ext_reset_request = 1'b0;
  logic             in_ext_reset_full = 1'b0;
  wire              out_valid;
  logic             out_stall = 1'b0;
  wire              out_test_leak;
  wire              out_inhibit_sleep;
  wire              out_hold_active;
  wire [CodeW-1:0]  out_reset_request;
  wire [CodeW-1:0]  out_beep;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [ApbAw-1:0] paddr = '0;
  logic [ApbDw-1:0] pwdata = '0;
  wire  [ApbDw-1:0] prdata;
  wire              pready;

  button_press_duration_classifier_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_now_ms            (in_now_ms),
    .in_pressed           (in_pressed),
    .in_ext_reset_request (in_ext_reset_request),
    .in_ext_reset_full    (in_ext_reset_full),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_test_leak        (out_test_leak),
    .out_inhibit_sleep    (out_inhibit_sleep),
    .out_hold_active      (out_hold_active),
    .out_reset_request    (out_reset_request),
    .out_beep             (out_beep),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: register mirror plus the tracking state of the classifier
  // ---------------------------------------------------------------------------
  logic            mode_enabled   = EnabledRst;
  logic [DurW-1:0] short_min      = ShortMinRst;
  logic [DurW-1:0] long_thr       = LongRst;
  logic [DurW-1:0] very_long_thr  = VeryLongRst;
  logic [DurW-1:0] ultra_long_thr = UltraLongRst;
  logic [InhW-1:0] inhibit_len    = InhibitRst;
  logic [DurW-1:0] leak_len       = LeakTestRst;

  logic            was_pressed    = 1'b0;
  logic [TsW-1:0]  press_began_ms = '0;
  logic [TsW-1:0]  inhibit_end_ms = '0;
  logic [TsW-1:0]  leak_end_ms    = '0;
  logic            leak_on        = 1'b0;
  logic            inhibit_on     = 1'b0;
  logic            hold_on        = 1'b0;

  tick_flags_t due_flags[$];   // one entry per accepted request, oldest first
  int unsigned err_count  = 0;
  int unsigned ticks_sent = 0;
  int unsigned burst_left = 0;
  logic [TsW-1:0] wall_ms = '0; // running timestamp for the random sessions

  // Advances the tracking state by one tick and returns the flags it shows.
  function automatic tick_flags_t classify_tick(input logic [TsW-1:0] now, input logic pr,
                                                input logic ext_req, input logic ext_full);
    tick_flags_t    r;
    logic [TsW-1:0] held;
    logic           rst_req;
    logic           rst_full;
    r = '0;
    if (mode_enabled) begin
      rst_req  = ext_req;
      rst_full = ext_full;
      if (pr && !was_pressed) begin
        press_began_ms = now;
        hold_on = 1'b1;
      end
      // long hold opens the inhibit window once per window
      if (pr && was_pressed) begin
        held = now - press_began_ms;
        if (held >= TsW'(long_thr) && !inhibit_on) begin
          inhibit_end_ms = now + TsW'(inhibit_len);
          inhibit_on = 1'b1;
          r.beep = BEEP_HOLD;
        end
      end
      // release: ultra-long first, then very-long, long, short, in that order
      if (!pr && was_pressed) begin
        held = now - press_began_ms;
        hold_on = 1'b0;
        if (held >= TsW'(ultra_long_thr)) begin
          rst_req  = 1'b1;
          rst_full = 1'b1;
          r.beep   = BEEP_DOUBLE;
        end else if (held >= TsW'(very_long_thr)) begin
          rst_req  = 1'b1;
          rst_full = 1'b0;
        end else if (held >= TsW'(long_thr)) begin
          // inhibit already handled while held
        end else if (held >= TsW'(short_min)) begin
          leak_end_ms = now + TsW'(leak_len);
          leak_on = 1'b1;
          r.beep = BEEP_SHORT;
        end
      end
      was_pressed = pr;
      // plain unsigned compare, no wrap awareness
      if (now > leak_end_ms) leak_on = 1'b0;
      if (now > inhibit_end_ms) inhibit_on = 1'b0;
      if (rst_req) r.req = rst_full ? REQ_FULL : REQ_CONFIG;
    end
    r.test_leak     = leak_on;
    r.inhibit_sleep = inhibit_on;
    r.hold_active   = hold_on;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    // keep the log bounded on a badly broken design
    if (err_count <= 40)
      $display("MISMATCH @%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_run  = 0;

  // Stall behavior changes in runs: none, sparse, dense, periodic.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(10, 150);
    end
    stall_run--;
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 7) == 0);
      2: out_stall = 1'($urandom_range(0, 1));
      default: out_stall = stall_run[2];
    endcase
  end

  tick_flags_t want_flags;

  // Outputs are sampled at the rising edge, before the DUT updates them.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_flags.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_beep), 32'd0);
      end else begin
        want_flags = due_flags.pop_front();
        if (out_test_leak !== want_flags.test_leak)
          report_mismatch("test_leak", 32'(out_test_leak), 32'(want_flags.test_leak));
        if (out_inhibit_sleep !== want_flags.inhibit_sleep)
          report_mismatch("inhibit_sleep", 32'(out_inhibit_sleep),
                          32'(want_flags.inhibit_sleep));
        if (out_hold_active !== want_flags.hold_active)
          report_mismatch("hold_active", 32'(out_hold_active), 32'(want_flags.hold_active));
        if (out_reset_request !== want_flags.req)
          report_mismatch("reset_request", 32'(out_reset_request), 32'(want_flags.req));
        if (out_beep !== want_flags.beep)
          report_mismatch("beep", 32'(out_beep), 32'(want_flags.beep));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Sends one tick. The sender works in bursts; between bursts valid drops for
  // a random gap that may be empty. Inside a burst valid stays high from request to request.
  task automatic send_tick(input logic [TsW-1:0] now, input logic pr, input logic ext_req,
                           input logic ext_full);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid             = 1'b1;
    in_now_ms            = now;
    in_pressed           = pr;
    in_ext_reset_request = ext_req;
    in_ext_reset_full    = ext_full;
    do @(posedge clk); while (in_stall);
    due_flags.push_back(classify_tick(now, pr, ext_req, ext_full));
    burst_left--;
    ticks_sent++;
  endtask

  // Advances the running timestamp and sends a tick, with a sporadic external request.
  task automatic step_tick(input int unsigned adv, input logic pr);
    logic er;
    er = ($urandom_range(0, 9) == 0);
    wall_ms = wall_ms + adv;
    send_tick(wall_ms, pr, er, 1'($urandom_range(0, 1)));
  endtask

  // Drops valid and waits until every result is back and the pipeline is empty.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ENABLED:    mode_enabled   = value[0];
      REG_SHORT_MIN:  short_min      = value[DurW-1:0];
      REG_LONG:       long_thr       = value[DurW-1:0];
      REG_VERY_LONG:  very_long_thr  = value[DurW-1:0];
      REG_ULTRA_LONG: ultra_long_thr = value[DurW-1:0];
      REG_INHIBIT:    inhibit_len    = value[InhW-1:0];
      REG_LEAK_TEST:  leak_len       = value[DurW-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Reads a register back and compares it with the mirror.
  task automatic check_reg(input reg_idx_t idx);
    logic [31:0] want;
    case (idx)
      REG_ENABLED:    want = {31'b0, mode_enabled};
      REG_SHORT_MIN:  want = {16'b0, short_min};
      REG_LONG:       want = {16'b0, long_thr};
      REG_VERY_LONG:  want = {16'b0, very_long_thr};
      REG_ULTRA_LONG: want = {16'b0, ultra_long_thr};
      REG_INHIBIT:    want = {10'b0, inhibit_len};
      default:        want = {16'b0, leak_len};
    endcase
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch({"readback of ", idx.name()}, prdata, want);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_all_regs();
    reg_idx_t r;
    r = r.first();
    do begin
      check_reg(r);
      r = r.next();
    end while (r != r.first());
  endtask

  // Loads a whole setting once the unit is idle, then reads it all back.
  task automatic set_config(input logic en, input logic [31:0] smin, input logic [31:0] lng,
                            input logic [31:0] vlong, input logic [31:0] ulong,
                            input logic [31:0] inh, input logic [31:0] leak);
    drain();
    write_reg(REG_ENABLED, 32'(en));
    write_reg(REG_SHORT_MIN, smin);
    write_reg(REG_LONG, lng);
    write_reg(REG_VERY_LONG, vlong);
    write_reg(REG_ULTRA_LONG, ulong);
    write_reg(REG_INHIBIT, inh);
    write_reg(REG_LEAK_TEST, leak);
    check_all_regs();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Defaults after reset; the unit starts disabled and must ignore ticks.
  task automatic test_reset_values();
    check_all_regs();
    send_tick(32'd100, 1'b1, 1'b1, 1'b1);
    send_tick(32'd30000, 1'b0, 1'b1, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
  endtask

  // Out-of-range bits are dropped and every register takes its extremes.
  task automatic test_register_access();
    set_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_config(1'b0, 0, 0, 0, 0, 0, 0);
    set_config(1'b1, 32'(ShortMinRst), 32'(LongRst), 32'(VeryLongRst), 32'(UltraLongRst),
               32'(InhibitRst), 32'(LeakTestRst));
  endtask

  // Directed presses with the default thresholds.
  task automatic test_press_classes();
    send_tick(32'd0, 1'b0, 1'b0, 1'b0);
    // press too short to count
    send_tick(32'd1000, 1'b1, 1'b0, 1'b0);
    send_tick(32'd1010, 1'b0, 1'b0, 1'b0);
    // short press opens the leak window; end compare is strictly greater
    send_tick(32'd2000, 1'b1, 1'b0, 1'b0);
    send_tick(32'd2100, 1'b0, 1'b0, 1'b0);
    send_tick(32'd4100, 1'b0, 1'b0, 1'b0);
    send_tick(32'd4101, 1'b0, 1'b0, 1'b0);
    // long hold: inhibit opens exactly at the threshold, release adds nothing
    send_tick(32'd5000, 1'b1, 1'b0, 1'b0);
    send_tick(32'd7999, 1'b1, 1'b0, 1'b0);
    send_tick(32'd8000, 1'b1, 1'b0, 1'b0);
    send_tick(32'd9000, 1'b0, 1'b0, 1'b0);
    // very long release beats an external full request on the same tick
    send_tick(32'd10000, 1'b1, 1'b0, 1'b0);
    send_tick(32'd20000, 1'b0, 1'b1, 1'b1);
    // ultra long release turns an external config request into a full one
    send_tick(32'd30000, 1'b1, 1'b0, 1'b0);
    send_tick(32'd50000, 1'b0, 1'b1, 1'b0);
    // external requests alone
    send_tick(32'd60000, 1'b0, 1'b1, 1'b0);
    send_tick(32'd60001, 1'b0, 1'b1, 1'b1);
    // inhibit window end
    send_tick(32'd308000, 1'b0, 1'b0, 1'b0);
    send_tick(32'd308001, 1'b0, 1'b0, 1'b0);
    // press across the timestamp wrap, then a leak end that wraps past zero
    send_tick(32'hFFFF_FF00, 1'b1, 1'b0, 1'b0);
    send_tick(32'h0000_0010, 1'b0, 1'b0, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_tick(32'hFFFF_FE00, 1'b1, 1'b0, 1'b0);
    send_tick(32'hFFFF_FF00, 1'b0, 1'b0, 1'b0);
  endtask

  // Thresholds set out of order: the ultra-long test still wins.
  task automatic test_threshold_order();
    set_config(1'b1, 400, 300, 200, 100, 50, 500);
    send_tick(32'd1000, 1'b1, 1'b0, 1'b0);
    send_tick(32'd1150, 1'b0, 1'b0, 1'b0);
    send_tick(32'd2000, 1'b1, 1'b0, 1'b0);
    send_tick(32'd2099, 1'b0, 1'b0, 1'b0);
  endtask

  // Disabled mid-press: state freezes, requests are dropped, flags still show.
  task automatic test_disabled_block();
    set_config(1'b1, 10, 100, 1000, 2000, 500, 300);
    send_tick(32'd5000, 1'b1, 1'b0, 1'b0);
    send_tick(32'd5200, 1'b1, 1'b0, 1'b0);
    drain();
    write_reg(REG_ENABLED, 32'd0);
    send_tick(32'd5300, 1'b0, 1'b1, 1'b1);
    send_tick(32'd9000, 1'b0, 1'b1, 1'b0);
    send_tick(32'd5400, 1'b1, 1'b0, 1'b0);
    drain();
    write_reg(REG_ENABLED, 32'd1);
    send_tick(32'd6100, 1'b0, 1'b0, 1'b0);
  endtask

  // One press with random content; its length lands near a threshold most of the time.
  task automatic press_session();
    int unsigned held, at, nxt, n_holds, k;
    k = $urandom_range(0, 5);
    case (k)
      0: held = 32'(short_min);
      1: held = 32'(long_thr);
      2: held = 32'(very_long_thr);
      3: held = 32'(ultra_long_thr);
      default: held = $urandom_range(0, 70000);
    endcase
    if (k < 4) begin
      held = held + $urandom_range(0, 4);
      held = (held >= 2) ? held - 2 : 0;
    end
    step_tick($urandom_range(1, 4000), 1'b1);
    at = 0;
    n_holds = $urandom_range(0, 4);
    for (k = 0; k < n_holds; k++) begin
      if ($urandom_range(0, 2) == 0 && 32'(long_thr) > at && 32'(long_thr) <= held)
        nxt = 32'(long_thr);
      else nxt = at + $urandom_range(0, held - at);
      step_tick(nxt - at, 1'b1);
      at = nxt;
    end
    step_tick(held - at, 1'b0);
    // idle ticks probing the window ends
    n_holds = $urandom_range(0, 3);
    for (k = 0; k < n_holds; k++) begin
      case ($urandom_range(0, 3))
        0: step_tick($urandom_range(0, 20), 1'b0);
        1: step_tick(32'(leak_len) + $urandom_range(0, 1), 1'b0);
        2: step_tick($urandom_range(0, 32'(inhibit_len) + 2), 1'b0);
        default: step_tick($urandom_range(0, 70000), 1'b0);
      endcase
    end
  endtask

  // Mostly well-formed press sessions, with noise, wraps and disabled spells.
  task automatic test_random_sessions(input int unsigned n_ticks);
    int unsigned goal, k;
    goal = ticks_sent + n_ticks;
    wall_ms = $urandom();
    while (ticks_sent < goal) begin
      case ($urandom_range(0, 39))
        0: wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 70000);
        1, 2: begin
          // noise: arbitrary timestamps and levels
          repeat ($urandom_range(1, 5))
            send_tick($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          wall_ms = in_now_ms;
        end
        3: begin
          drain();
          write_reg(REG_ENABLED, 32'd0);
          for (k = $urandom_range(1, 4); k > 0; k--)
            step_tick($urandom_range(0, 5000), 1'($urandom_range(0, 1)));
          drain();
          write_reg(REG_ENABLED, 32'd1);
        end
        default: press_session();
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_register_access();
    test_press_classes();
    test_threshold_order();
    test_disabled_block();

    // small thresholds so every class shows up often
    set_config(1'b1, 5, 300, 1000, 2000, 5000, 200);
    test_random_sessions(240);
    // everything zero: any hold inhibits, any release of a held button is ultra-long
    set_config(1'b1, 0, 0, 0, 0, 0, 0);
    test_random_sessions(240);
    // everything at its maximum
    set_config(1'b1, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h3F_FFFF, 32'hFFFF);
    test_random_sessions(240);
    // thresholds out of order
    set_config(1'b1, 4000, 3000, 1000, 2000, 700, 3000);
    test_random_sessions(240);
    // reset defaults
    set_config(1'b1, 32'(ShortMinRst), 32'(LongRst), 32'(VeryLongRst), 32'(UltraLongRst),
               32'(InhibitRst), 32'(LeakTestRst));
    test_random_sessions(240);
    // random setting
    set_config(1'b1, $urandom_range(0, 200), $urandom_range(0, 3000),
               $urandom_range(0, 20000), $urandom_range(0, 65535),
               $urandom_range(0, 400000), $urandom_range(0, 5000));
    test_random_sessions(240);

    drain();
    if (err_count == 0) begin
      $display("button_press_duration_classifier_unit verification clean");
    end else begin
      $display("button_press_duration_classifier_unit verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #4000000;
    $display("button_press_duration_classifier_unit verification failed");
    $finish;
  end

endmodule
`default_nettype wire
